>>> src/c_comment_literal_blanker_unit_assert.svh
// Assertion macros shared by the checkers of the comment and literal blanker.
// No dependencies; include with the bare file name.
`ifndef C_COMMENT_LITERAL_BLANKER_UNIT_ASSERT_SVH
`define C_COMMENT_LITERAL_BLANKER_UNIT_ASSERT_SVH

// Clocked assertion, ignored while reset is high.
`define CLB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CLB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/clb_pkg.sv
// Package for the comment and literal blanker: character codes, lexer modes,
// lexer result struct and output queue sizing. No dependencies.
package clb_pkg;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [2:0] {
    MODE_CODE  = 3'd0,
    MODE_LINE  = 3'd1,
    MODE_BLOCK = 3'd2,
    MODE_STR   = 3'd3,
    MODE_CHR   = 3'd4
  } mode_t;

  // Output queue: four entries, room for a two-byte step while one drains.
  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // Bytes produced by one lexer step (cnt is 0, 1 or 2).
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] data0;
    logic [7:0] data1;
    logic       last;
  } clb_res_t;

endpackage

>>> src/clb_lexer.sv
// Lexer state and per-byte classification for the comment and literal blanker.
// Depends on clb_pkg.
module clb_lexer
  import clb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output clb_res_t   res
);

  mode_t mode, mode_next;
  logic  slash_held, slash_held_next;
  logic  star_seen, star_seen_next;
  logic  escape_next, escape_next_next;

  function automatic logic [7:0] blank_of(input logic [7:0] b);
    return (b == CH_NL) ? CH_NL : CH_SPACE;
  endfunction

  always_comb begin
    mode_next        = mode;
    slash_held_next  = slash_held;
    star_seen_next   = star_seen;
    escape_next_next = escape_next;
    res.cnt          = 2'd1;
    res.data0        = blank_of(in_byte);
    res.data1        = CH_SPACE;
    res.last         = in_last;
    unique case (mode)
      MODE_LINE: begin
        if (in_byte == CH_NL) mode_next = MODE_CODE;
      end
      MODE_BLOCK: begin
        if (star_seen && in_byte == CH_SLASH) begin
          mode_next      = MODE_CODE;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (in_byte == CH_STAR);
        end
      end
      MODE_STR, MODE_CHR: begin
        if (escape_next) begin
          escape_next_next = 1'b0;
        end else if (in_byte == CH_BSLASH) begin
          escape_next_next = 1'b1;
        end else if ((mode == MODE_STR && in_byte == CH_DQUOTE) ||
                     (mode == MODE_CHR && in_byte == CH_SQUOTE)) begin
          mode_next = MODE_CODE;
        end
      end
      default: begin
        mode_next = MODE_CODE;
        if (slash_held) begin
          slash_held_next = 1'b0;
          res.cnt         = 2'd2;
          if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
            res.data0      = CH_SPACE;
            res.data1      = CH_SPACE;
            mode_next      = (in_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            star_seen_next = 1'b0;
          end else begin
            // release the held slash, then treat the byte as code
            res.data0 = CH_SLASH;
            res.data1 = in_byte;
            if (in_byte == CH_DQUOTE) begin
              res.data1        = CH_AT;
              mode_next        = MODE_STR;
              escape_next_next = 1'b0;
            end else if (in_byte == CH_SQUOTE) begin
              res.data1        = CH_DOLLAR;
              mode_next        = MODE_CHR;
              escape_next_next = 1'b0;
            end
          end
        end else begin
          res.data0 = in_byte;
          if (in_byte == CH_SLASH) begin
            if (!in_last) begin
              slash_held_next = 1'b1;
              res.cnt         = 2'd0;
            end
          end else if (in_byte == CH_DQUOTE) begin
            res.data0        = CH_AT;
            mode_next        = MODE_STR;
            escape_next_next = 1'b0;
          end else if (in_byte == CH_SQUOTE) begin
            res.data0        = CH_DOLLAR;
            mode_next        = MODE_CHR;
            escape_next_next = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CODE;
      slash_held  <= 1'b0;
      star_seen   <= 1'b0;
      escape_next <= 1'b0;
    end else if (step) begin
      if (in_last) begin
        // end of source: back to reset state whatever the mode
        mode        <= MODE_CODE;
        slash_held  <= 1'b0;
        star_seen   <= 1'b0;
        escape_next <= 1'b0;
      end else begin
        mode        <= mode_next;
        slash_held  <= slash_held_next;
        star_seen   <= star_seen_next;
        escape_next <= escape_next_next;
      end
    end
  end

endmodule

>>> src/clb_outq.sv
// Output queue for the blanker: takes zero to two bytes per step, gives one
// per transfer on the master side. Depends on clb_pkg.
module clb_outq
  import clb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  clb_res_t   res,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,
  output logic       out_last
);

  logic [8:0]       mem [QDEPTH];
  logic [QPTRW-1:0] wr_ptr, rd_ptr;
  logic [QCNTW-1:0] count;
  logic             pop;
  logic [1:0]       n_push;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= QCNTW'(QDEPTH - 2));
  assign n_push    = push ? res.cnt : 2'd0;
  assign out_data  = mem[rd_ptr][7:0];
  assign out_last  = mem[rd_ptr][8];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= {res.last && (n_push == 2'd1), res.data0};
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + QPTRW'(1)] <= {res.last, res.data1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTRW'(n_push);
      if (pop) rd_ptr <= rd_ptr + QPTRW'(1);
      count <= count + QCNTW'(n_push) - QCNTW'(pop);
    end
  end

endmodule

>>> src/c_comment_literal_blanker_unit.sv
// A slave-side transfer is captured in the input register; its lexer result is then written
// to the output queue; a held slash comes out with the following byte. Throughput: one
// source byte per cycle while the queue has room; a byte that yields two output bytes
// occupies the master side for two transfers, set by the single read port of the queue.
// Reset (rst, synchronous, active high) empties the input register and the output
// queue and puts the lexer back in code mode.
module c_comment_literal_blanker_unit
  import clb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] src_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] clean_byte
  output logic       m_axis_tlast
);

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;
  logic       room;
  logic       step;
  clb_res_t   res;

  assign step          = in_vld && room;
  assign s_axis_tready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  clb_lexer u_lexer (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  clb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .res       (res),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

>>> src/clb_checker.sv
// Port-level checks for c_comment_literal_blanker_unit, bound to the top level.
// Depends on c_comment_literal_blanker_unit_assert.svh.
`include "c_comment_literal_blanker_unit_assert.svh"

module clb_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled output holds
  `CLB_ASSERT(a_m_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "master side changed while stalled")

  // offered input holds until taken
  `CLB_ASSERT(a_s_hold, clk, rst, s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast), "slave side changed while stalled")

  // reset leaves nothing queued and the input open
  `CLB_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid && s_axis_tready, "not empty after reset")

  // input stalls only while output bytes are pending
  `CLB_ASSERT(a_stall_cause, clk, rst, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

endmodule

bind c_comment_literal_blanker_unit clb_checker u_clb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_c_comment_literal_blanker_unit.sv
// Self-checking testbench for c_comment_literal_blanker_unit: a scoreboard class predicts
// the blanked byte stream, and initial blocks drive both stream sides with random stalls.
// Depends on clb_pkg and the unit RTL.
module tb_c_comment_literal_blanker_unit;
  import clb_pkg::*;

  localparam int ITEMS       = 1750;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 80;
  localparam int PAUSE_AT    = 1000;
  localparam int DRAIN       = 10;

  localparam logic [7:0] LEX_CHARS [6] = '{CH_SLASH, CH_STAR, CH_DQUOTE, CH_SQUOTE,
                                            CH_BSLASH, CH_NL};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  class blank_scoreboard;
    mode_t      mode;
    bit         slash_held;
    bit         star_seen;
    bit         escape_next;
    logic [7:0] step_out[$];
    byte_item_t clean_q[$];
    int         n_in;
    int         n_out;
    int         n_err;
    int         n_double;
    int         n_streams;

    function new();
      reset_lexer();
    endfunction

    function void reset_lexer();
      mode        = MODE_CODE;
      slash_held  = 1'b0;
      star_seen   = 1'b0;
      escape_next = 1'b0;
    endfunction

    function logic [7:0] blank_of(logic [7:0] b);
      return (b == CH_NL) ? CH_NL : CH_SPACE;
    endfunction

    // Code-mode byte with no slash pending; a slash is held unless it ends the stream.
    function void code_char(logic [7:0] b, logic l);
      if (b == CH_SLASH) begin
        if (l) step_out.push_back(CH_SLASH);
        else slash_held = 1'b1;
      end else if (b == CH_DQUOTE) begin
        mode        = MODE_STR;
        escape_next = 1'b0;
        step_out.push_back(CH_AT);
      end else if (b == CH_SQUOTE) begin
        mode        = MODE_CHR;
        escape_next = 1'b0;
        step_out.push_back(CH_DOLLAR);
      end else begin
        step_out.push_back(b);
      end
    endfunction

    function void note_source(logic [7:0] b, logic l);
      step_out.delete();
      n_in++;
      case (mode)
        MODE_LINE: begin
          step_out.push_back(blank_of(b));
          if (b == CH_NL) mode = MODE_CODE;
        end
        MODE_BLOCK: begin
          step_out.push_back(blank_of(b));
          if (star_seen && b == CH_SLASH) begin
            mode      = MODE_CODE;
            star_seen = 1'b0;
          end else begin
            star_seen = (b == CH_STAR);
          end
        end
        MODE_STR, MODE_CHR: begin
          step_out.push_back(blank_of(b));
          if (escape_next) escape_next = 1'b0;
          else if (b == CH_BSLASH) escape_next = 1'b1;
          else if ((mode == MODE_STR && b == CH_DQUOTE) ||
                   (mode == MODE_CHR && b == CH_SQUOTE)) mode = MODE_CODE;
        end
        default: begin
          mode = MODE_CODE;
          if (slash_held) begin
            slash_held = 1'b0;
            if (b == CH_SLASH || b == CH_STAR) begin
              step_out.push_back(CH_SPACE);
              step_out.push_back(CH_SPACE);
              mode      = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
              star_seen = 1'b0;
            end else begin
              step_out.push_back(CH_SLASH);
              code_char(b, l);
            end
          end else begin
            code_char(b, l);
          end
        end
      endcase
      foreach (step_out[k])
        clean_q.push_back('{data: step_out[k], last: l && (k == step_out.size() - 1)});
      if (step_out.size() == 2) n_double++;
      if (l) begin
        n_streams++;
        reset_lexer();
      end
    endfunction

    function void report(string msg);
      if (n_err < 10) $display("mismatch at %0t: %s", $time, msg);
      n_err++;
    endfunction

    function void check_clean(logic [7:0] b, logic l);
      byte_item_t want;
      n_out++;
      if (clean_q.size() == 0) begin
        report($sformatf("unexpected transfer clean_byte=%02h clean_last=%0b", b, l));
        return;
      end
      want = clean_q.pop_front();
      if (want.data !== b)
        report($sformatf("transfer %0d clean_byte expected %02h got %02h",
                         n_out, want.data, b));
      if (want.last !== l)
        report($sformatf("transfer %0d clean_last expected %0b got %0b",
                         n_out, want.last, l));
    endfunction

    function int pending();
      return clean_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] src_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] clean_byte
  logic       m_axis_tlast;
  logic       sink_hold = 1'b0;

  blank_scoreboard sb = new();
  byte_item_t      src_q[$];

  c_comment_literal_blanker_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  function void push_src(logic [7:0] b, logic l);
    src_q.push_back('{data: b, last: l});
  endfunction

  function logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mix of lexer-relevant characters and arbitrary bytes.
  function logic [7:0] lex_byte();
    if ($urandom_range(0, 9) < 4) return LEX_CHARS[$urandom_range(0, 5)];
    return any_byte();
  endfunction

  // Append one token-shaped fragment of source text.
  function void add_fragment();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(0, 6);
    case (kind)
      0, 1: begin
        repeat (len + 1) push_src(any_byte(), 1'b0);
      end
      2: begin
        push_src(CH_SLASH, 1'b0);
        push_src(CH_SLASH, 1'b0);
        repeat (len) push_src(any_byte(), 1'b0);
        push_src(CH_NL, 1'b0);
      end
      3: begin
        push_src(CH_SLASH, 1'b0);
        push_src(CH_STAR, 1'b0);
        repeat (len) push_src(($urandom_range(0, 3) == 0) ? CH_STAR : any_byte(), 1'b0);
        push_src(CH_STAR, 1'b0);
        push_src(CH_SLASH, 1'b0);
      end
      4, 5: begin
        push_src(CH_DQUOTE, 1'b0);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) push_src(CH_BSLASH, 1'b0);
          push_src(any_byte(), 1'b0);
        end
        push_src(CH_DQUOTE, 1'b0);
      end
      6: begin
        push_src(CH_SQUOTE, 1'b0);
        if ($urandom_range(0, 1) == 1) push_src(CH_BSLASH, 1'b0);
        push_src(any_byte(), 1'b0);
        push_src(CH_SQUOTE, 1'b0);
      end
      7: begin
        push_src(CH_SLASH, 1'b0);
        push_src(lex_byte(), 1'b0);
      end
      default: begin
        repeat (len + 1) push_src(lex_byte(), 1'b0);
      end
    endcase
    if ($urandom_range(0, 24) == 0) src_q[$].last = 1'b1;
  endfunction

  // Source side.
  initial begin
    int  gap;
    bit  src_burst;
    bit  pause;

    push_src(8'h00, 1'b0);
    push_src(8'hFF, 1'b0);
    push_src(CH_SLASH, 1'b0);   // slash followed by ordinary byte
    push_src(8'h61, 1'b0);
    push_src(CH_SLASH, 1'b0);   // slash followed by string opener
    push_src(CH_DQUOTE, 1'b0);
    push_src(CH_BSLASH, 1'b0);  // escaped quote stays inside
    push_src(CH_DQUOTE, 1'b0);
    push_src(CH_DQUOTE, 1'b0);
    push_src(CH_SQUOTE, 1'b0);
    push_src(CH_BSLASH, 1'b0);
    push_src(CH_SQUOTE, 1'b0);
    push_src(CH_SQUOTE, 1'b0);
    push_src(CH_SLASH, 1'b0);   // line comment
    push_src(CH_SLASH, 1'b0);
    push_src(CH_NL, 1'b0);
    push_src(CH_SLASH, 1'b0);   // opener star must not close the block
    push_src(CH_STAR, 1'b0);
    push_src(CH_SLASH, 1'b0);
    push_src(CH_STAR, 1'b0);
    push_src(CH_SLASH, 1'b0);
    push_src(CH_SLASH, 1'b1);   // slash as final byte
    push_src(CH_DQUOTE, 1'b0);
    push_src(CH_BSLASH, 1'b1);  // backslash as final byte, stream ends inside a string
    push_src(CH_SLASH, 1'b0);
    push_src(CH_STAR, 1'b1);    // stream ends inside a block comment
    while (src_q.size() < ITEMS) add_fragment();
    push_src(any_byte(), 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    src_burst = 1'b0;
    for (int i = 0; i < src_q.size(); i++) begin
      if (i % 64 == 0) src_burst = ($urandom_range(0, 3) == 0);
      pause = (i == PAUSE_AT);
      gap = (src_burst || (i >= HOLD_AT && i < HOLD_AT + 160)) ? 0 : $urandom_range(0, 10);
      if (pause && gap == 0) gap = 1;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        while (pause && sb.pending() != 0) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= src_q[i].data;
      s_axis_tlast  <= src_q[i].last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      sb.note_source(src_q[i].data, src_q[i].last);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected transfers never arrived", sb.pending()));
    $display("run: %0d source bytes in %0d streams, %0d clean bytes checked, %0d two-byte steps",
             sb.n_in, sb.n_streams, sb.n_out, sb.n_double);
    $display("mismatches: %0d", sb.n_err);
    if (sb.n_err == 0) begin
      $display("tb_c_comment_literal_blanker_unit: clean");
    end else begin
      $display("tb_c_comment_literal_blanker_unit: errors");
    end
    $finish;
  end

  // Result side.
  initial begin
    int gap;
    bit sink_burst;

    sink_burst = 1'b0;
    while (rst) @(posedge clk);
    for (int n = 0; ; n++) begin
      if (n % 100 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      gap = sink_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0 || sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (sink_hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_clean(m_axis_tdata, m_axis_tlast);
    end
  end

  // Stall the result side once while the source streams without gaps.
  initial begin
    while (sb.n_in < HOLD_AT) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    #1000000;
    $display("timeout at %0t", $time);
    $display("tb_c_comment_literal_blanker_unit: errors");
    $finish;
  end

endmodule
